// File: hdl/acrq_pkg.sv
// Shared types for the ADC conversion request queue.
// No dependencies; used by the interfaces, the queue cell and the top level.
package acrq_pkg;

  typedef enum logic {
    REQ_NEW  = 1'b0,
    REQ_DONE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_OFF      = 2'd1,
    KIND_REPORT   = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [3:0]  requester_id;
    logic [7:0]  vref_bits;
    logic [7:0]  mux_channel;
    logic [9:0]  sample_value;
  } req_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [7:0]  mux_word;
    logic [3:0]  report_id;
    logic [9:0]  report_value;
    logic        last;
  } res_t;

  // One queued request: the requester and its precombined mux word.
  typedef struct packed {
    logic [3:0] id;
    logic [7:0] mux;
  } entry_t;

  typedef struct packed {
    logic load;   // take the new entry
    logic shift;  // take the neighbour's entry
  } cell_ctrl_t;

endpackage

// File: hdl/acrq_if.sv
// Valid/ready channels for requests and results.
// Depends on acrq_pkg for the payload types.
interface acrq_req_if import acrq_pkg::*;;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface acrq_res_if import acrq_pkg::*;;
  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/acrq_cell.sv
// One slot of the shifting request queue.
// Depends on acrq_pkg for entry_t and cell_ctrl_t.
module acrq_cell import acrq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     next_i,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.shift) begin
      entry_d = next_i;
    end else if (ctrl_i.load) begin
      entry_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/adc_conversion_request_queue.sv
// ADC conversion request queue: top level.
// Depends on acrq_pkg, acrq_req_if / acrq_res_if and acrq_cell.
//
// Usage: items on req_i are either new conversion requests or conversion
// complete events. Requests are held in a row of QUEUE_DEPTH cells with the
// head in cell 0; a completion shifts every cell one place towards the head.
// Results leave on res_o: a start command, a converter-off notice, a measure
// report or an overflow flag, with last set on the final result of an item.
// Latency: the first result of an item appears on res_o the cycle after it is taken.
// Throughput: one item per cycle for items with at most one result while res_o
// is ready; a completion on a non-empty queue yields two results and blocks
// req_i while the second result waits in the spare output slot.
// Reset: the queue empties and the converter counts as idle; cell contents
// are not cleared and are never read before being written.
// Stall: while the output slot is empty, req_i keeps taking items that give no
// result even with res_o stalled; the first item with a result fills the output slot,
// after which ready holds low until the slot empties.
module adc_conversion_request_queue import acrq_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  acrq_req_if.sink    req_i,
  acrq_res_if.source  res_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  entry_t          cell_q    [QUEUE_DEPTH];
  cell_ctrl_t      cell_ctrl [QUEUE_DEPTH];
  entry_t          new_entry;

  logic accept, full, empty, is_new, out_take;
  logic first_valid, second_valid;
  res_t first_res, second_res;

  res_t out_q, pend_q;
  logic out_valid_q, pend_valid_q;

  assign req_i.ready = !pend_valid_q && (!out_valid_q || res_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign out_take    = out_valid_q && res_o.ready;
  assign is_new      = (req_i.payload.req_type == REQ_NEW);
  assign full        = (count_q == CntW'(QUEUE_DEPTH));
  assign empty       = (count_q == '0);

  assign new_entry.id  = req_i.payload.requester_id;
  assign new_entry.mux = req_i.payload.vref_bits | req_i.payload.mux_channel;

  // Row of cells; the tail cell re-takes its own entry on a shift.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t next_entry;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_entry = cell_q[i];
    end else begin : g_mid
      assign next_entry = cell_q[i+1];
    end

    assign cell_ctrl[i].load  = accept && is_new && !full && (count_q == CntW'(i));
    assign cell_ctrl[i].shift = accept && !is_new && !empty;

    acrq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .new_i   (new_entry),
      .next_i  (next_entry),
      .entry_o (cell_q[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    first_valid  = 1'b0;
    second_valid = 1'b0;
    first_res    = '0;
    second_res   = '0;
    if (accept) begin
      if (is_new) begin
        if (full) begin
          first_valid           = 1'b1;
          first_res.result_kind = KIND_OVERFLOW;
          first_res.last        = 1'b1;
        end else begin
          count_d = count_q + 1'b1;
          // Converter idle exactly when the queue was empty.
          if (empty) begin
            first_valid           = 1'b1;
            first_res.result_kind = KIND_START;
            first_res.mux_word    = new_entry.mux;
            first_res.last        = 1'b1;
          end
        end
      end else if (!empty) begin
        count_d      = count_q - 1'b1;
        first_valid  = 1'b1;
        second_valid = 1'b1;
        if (count_q > CntW'(1)) begin
          first_res.result_kind = KIND_START;
          first_res.mux_word    = cell_q[1].mux;
        end else begin
          first_res.result_kind = KIND_OFF;
        end
        second_res.result_kind  = KIND_REPORT;
        second_res.report_id    = cell_q[0].id;
        second_res.report_value = req_i.payload.sample_value;
        second_res.last         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (out_take) begin
        out_valid_q  <= pend_valid_q;
        pend_valid_q <= 1'b0;
      end
      if (first_valid) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= second_valid;
      end
    end
  end

  // Output slot and spare slot payloads; advance the spare on a take.
  always_ff @(posedge clk_i) begin
    if (first_valid) begin
      out_q  <= first_res;
      pend_q <= second_res;
    end else if (out_take && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

endmodule

// File: test/tb_adc_conversion_request_queue.sv
`timescale 1ns / 100ps
// Testbench for adc_conversion_request_queue: random and directed request/completion items,
// checked against a scoreboard that tracks the pending queue and the converter state.
// Depends on acrq_pkg, acrq_req_if / acrq_res_if and the block itself.
module tb_adc_conversion_request_queue;
  import acrq_pkg::*;

  localparam int QUEUE_DEPTH = 8;
  localparam int MAX_PRINTED = 40;

  // Scoreboard: mirrors the pending queue and the converter state, and holds the
  // commands and reports the block owes.
  class conversion_board;
    entry_t  pending[$];
    bit      converter_on;
    res_t    owed_results[$];
    int      errors;
    int      checked;
    int      n_requests;
    int      n_overflows;
    int      n_completions;
    int      n_empty_completions;

    function res_t make_result(kind_e k, logic [7:0] m, logic [3:0] id, logic [9:0] v,
                               logic l);
      res_t r;
      r.result_kind  = k;
      r.mux_word     = m;
      r.report_id    = id;
      r.report_value = v;
      r.last         = l;
      return r;
    endfunction

    function void note_item(req_t it);
      entry_t e;
      if (it.req_type == REQ_NEW) begin
        n_requests++;
        if (pending.size() >= QUEUE_DEPTH) begin
          n_overflows++;
          owed_results.push_back(make_result(KIND_OVERFLOW, 8'h00, 4'h0, 10'h000, 1'b1));
        end else begin
          e.id  = it.requester_id;
          e.mux = it.vref_bits | it.mux_channel;
          pending.push_back(e);
          if (!converter_on) begin
            converter_on = 1'b1;
            owed_results.push_back(make_result(KIND_START, pending[0].mux, 4'h0, 10'h000,
                                               1'b1));
          end
        end
      end else begin
        n_completions++;
        if (pending.size() == 0) begin
          n_empty_completions++;
        end else begin
          e = pending.pop_front();
          if (pending.size() != 0) begin
            converter_on = 1'b1;
            owed_results.push_back(make_result(KIND_START, pending[0].mux, 4'h0, 10'h000,
                                               1'b0));
          end else begin
            converter_on = 1'b0;
            owed_results.push_back(make_result(KIND_OFF, 8'h00, 4'h0, 10'h000, 1'b0));
          end
          owed_results.push_back(make_result(KIND_REPORT, 8'h00, e.id, it.sample_value,
                                             1'b1));
        end
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      if (errors < MAX_PRINTED)
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result, kind", int'(got.result_kind), -1);
        return;
      end
      want = owed_results.pop_front();
      checked++;
      if (got.result_kind !== want.result_kind)
        report_mismatch("result_kind", int'(got.result_kind), int'(want.result_kind));
      if (got.mux_word !== want.mux_word)
        report_mismatch("mux_word", int'(got.mux_word), int'(want.mux_word));
      if (got.report_id !== want.report_id)
        report_mismatch("report_id", int'(got.report_id), int'(want.report_id));
      if (got.report_value !== want.report_value)
        report_mismatch("report_value", int'(got.report_value), int'(want.report_value));
      if (got.last !== want.last)
        report_mismatch("last", int'(got.last), int'(want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   src_idle_pct = 0;
  int   sink_idle_pct = 0;

  conversion_board board = new();

  acrq_req_if req_ch ();
  acrq_res_if res_ch ();

  adc_conversion_request_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .res_o (res_ch)
  );

  always #6 clk_i = ~clk_i;

  // Result side: random stalls, check every accepted result.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_ch.valid && res_ch.ready) board.check_result(res_ch.payload);
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function req_t make_request(logic [3:0] id, logic [7:0] vref, logic [7:0] chan);
    req_t it;
    it.req_type     = REQ_NEW;
    it.requester_id = id;
    it.vref_bits    = vref;
    it.mux_channel  = chan;
    it.sample_value = 10'($urandom);
    return it;
  endfunction

  function req_t make_completion(logic [9:0] sample);
    req_t it;
    it.req_type     = REQ_DONE;
    it.requester_id = 4'($urandom);
    it.vref_bits    = 8'($urandom);
    it.mux_channel  = 8'($urandom);
    it.sample_value = sample;
    return it;
  endfunction

  // Offer one item, idling beforehand at random, and hold it until taken.
  task automatic push_item(input req_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= it;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    board.note_item(it);
  endtask

  // Hold off the sender until every owed result has arrived.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (board.owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Bursts that fill, drain or balance the queue, so that overflows and
  // converter-off notices both come up often.
  task automatic run_random(input int n_items, input int src_pct, input int sink_pct);
    int   counted;
    int   burst_left;
    int   req_pct;
    req_t it;
    counted       = 0;
    burst_left    = 0;
    req_pct       = 50;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    while (counted < n_items) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(60, 10);
        case ($urandom_range(2))
          0: req_pct = 80;
          1: req_pct = 25;
          default: req_pct = 52;
        endcase
      end
      burst_left--;
      if ($urandom_range(99) < req_pct)
        it = make_request(4'($urandom), 8'($urandom), 8'($urandom));
      else
        it = make_completion(10'($urandom));
      counted++;
      push_item(it);
    end
  endtask

  initial begin
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty completion, fill to overflow, drain to off, restart.
    push_item(make_completion(10'h3FF));
    push_item(make_request(4'h0, 8'h00, 8'h00));
    push_item(make_request(4'hF, 8'hFF, 8'h00));
    push_item(make_request(4'h5, 8'h00, 8'hFF));
    push_item(make_request(4'hA, 8'hAA, 8'h55));
    push_item(make_request(4'h1, 8'h0F, 8'h0F));
    push_item(make_request(4'h2, 8'h80, 8'h01));
    push_item(make_request(4'h3, 8'h00, 8'h7E));
    push_item(make_request(4'hC, 8'hF0, 8'h0F));
    push_item(make_request(4'h9, 8'hFF, 8'hFF));
    push_item(make_completion(10'h000));
    push_item(make_completion(10'h3FF));
    push_item(make_completion(10'h155));
    push_item(make_completion(10'h2AA));
    push_item(make_completion(10'h001));
    push_item(make_completion(10'h200));
    push_item(make_completion(10'h0FF));
    push_item(make_completion(10'h300));
    push_item(make_completion(10'h123));
    push_item(make_request(4'h3, 8'h0F, 8'hF0));
    push_item(make_completion(10'h3FE));
    wait_drained();

    run_random(600, 37, 72);
    wait_drained();
    run_random(580, 72, 37);
    wait_drained();
    run_random(570, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d requests (%0d overflowed) and %0d completions (%0d on an empty",
             board.n_requests, board.n_overflows, board.n_completions,
             board.n_empty_completions);
    $display("queue); %0d results checked, %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0 && board.owed_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still owed.", board.owed_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
hdl/acrq_pkg.sv
hdl/acrq_if.sv
hdl/acrq_cell.sv
hdl/adc_conversion_request_queue.sv
test/tb_adc_conversion_request_queue.sv
